FILE: sv/tbabf_pkg.sv
// ----------------------------------------------------------------------------
// tbabf_pkg: shared constants for the two-bank ageing membership filter
// Field widths, register reset value and parameter defaults.
// ----------------------------------------------------------------------------
package tbabf_pkg;

  localparam int IDX_W         = 12;   // width of one hashed bit index
  localparam int THR_W         = 13;   // width of the swap threshold register
  localparam int THR_RESET     = 2048; // threshold after reset
  localparam int SIZE_DEFAULT  = 4096; // bits per bank
  localparam int NHASH_DEFAULT = 4;    // indices used per query
  localparam int RAM_W_DEFAULT = 1;

endpackage

FILE: sv/two_bank_aging_bloom_filter_top.sv
// ----------------------------------------------------------------------------
// two_bank_aging_bloom_filter_top: two-bank ageing membership filter
// Recent/old bit banks in single-port RAMs, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Each input beat carries up to NHASH hashed bit indices (index modulo SIZE is
// used) and a lookup_only flag; each one gives exactly one output beat with
// present. After reset the block clears both banks, one address a cycle, and
// in_stall_o stays high until that sweep is done. Per query the RAM port is
// the bottleneck: the sequencer reads both banks in parallel at each index,
// evaluates, then hands the result to the output register; a hit in the
// recent bank goes straight from evaluation to that hand-off. A miss that
// inserts adds a write at each index plus a threshold check; a lookup-only
// miss adds the check only. A bank swap clears the old bank with a sweep over
// all SIZE addresses, then re-inserts the query unless it is lookup-only. The
// output register lets the next query be accepted while the previous result
// is still stalled. The threshold port is always ready; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
module two_bank_aging_bloom_filter_top #(
  parameter int SIZE  = tbabf_pkg::SIZE_DEFAULT,
  parameter int NHASH = tbabf_pkg::NHASH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // query channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tbabf_pkg::IDX_W-1:0] index_0_i,
  input  logic [tbabf_pkg::IDX_W-1:0] index_1_i,
  input  logic [tbabf_pkg::IDX_W-1:0] index_2_i,
  input  logic [tbabf_pkg::IDX_W-1:0] index_3_i,
  input  logic                        lookup_only_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        present_o,
  // threshold write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tbabf_pkg::THR_W-1:0] swap_threshold_i
);

  localparam int AW   = $clog2(SIZE);                 // bank address width
  localparam int CW   = $clog2(SIZE + 1);             // fill count width
  localparam int CNW  = $clog2(NHASH + 1);            // step counter width
  localparam int CMPW = (CW > tbabf_pkg::THR_W) ? CW : tbabf_pkg::THR_W;
  localparam int IW   = tbabf_pkg::IDX_W;

  // one-hot sequencer
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,  // post-reset sweep of both banks
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,  // read both banks at every index
    S_EVAL  = 9'b000001000,
    S_INS   = 9'b000010000,  // set bits in recent bank
    S_CHK   = 9'b000100000,  // threshold check
    S_SWEEP = 9'b001000000,  // clear old bank
    S_REINS = 9'b010000000,  // insert into freshly cleared bank
    S_DONE  = 9'b100000000   // hand result to output register
  } state_e;

  state_e            state_q, state_d;
  logic [CNW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic [AW-1:0]     pos_q [NHASH];
  logic [AW-1:0]     pos_d [NHASH];
  logic [NHASH-1:0]  uniq_q, uniq_d;   // first occurrence of each position
  logic [NHASH-1:0]  rz_q, rz_d;       // recent bit was clear
  logic [NHASH-1:0]  oz_q, oz_d;       // old bit was clear
  logic              lookup_q, lookup_d;
  logic              present_q, present_d;
  logic              recent_q, recent_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [tbabf_pkg::THR_W-1:0] thr_q;
  logic              out_valid_q, out_valid_d;
  logic              out_present_q, out_present_d;

  logic [IW-1:0]     idx_in [4];
  logic [AW-1:0]     pos_in [NHASH];
  logic [NHASH-1:0]  uniq_in;
  logic              in_acc;

  logic [AW-1:0]     ram_addr;
  logic              ram_wdata;
  logic              we0, we1;
  logic              rd0, rd1;
  logic              rd_recent, rd_old;

  // index modulo SIZE by shifted compare-and-subtract; SIZE >= 16 keeps it
  // to eight steps for a 12-bit index
  function automatic logic [AW-1:0] reduce_pos(input logic [IW-1:0] idx);
    logic [31:0] v;
    logic [31:0] m;
    v = 32'(idx);
    for (int k = 7; k >= 0; k--) begin
      m = 32'(SIZE) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] pop(input logic [NHASH-1:0] v);
    logic [CW-1:0] s;
    s = '0;
    for (int i = 0; i < NHASH; i++) begin
      s = s + CW'(v[i]);
    end
    return s;
  endfunction

  assign idx_in[0] = index_0_i;
  assign idx_in[1] = index_1_i;
  assign idx_in[2] = index_2_i;
  assign idx_in[3] = index_3_i;

  always_comb begin
    for (int k = 0; k < NHASH; k++) begin
      pos_in[k] = reduce_pos(idx_in[k]);
    end
    for (int k = 0; k < NHASH; k++) begin
      uniq_in[k] = 1'b1;
      for (int j = 0; j < k; j++) begin
        if (pos_in[j] == pos_in[k]) begin
          uniq_in[k] = 1'b0;
        end
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign present_o   = out_present_q;

  // one address bus for both banks
  assign ram_addr  = (state_q == S_CLEAR || state_q == S_SWEEP) ? sweep_q : pos_q[0];
  assign ram_wdata = (state_q == S_INS || state_q == S_REINS);
  assign rd_recent = recent_q ? rd1 : rd0;
  assign rd_old    = recent_q ? rd0 : rd1;

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    if (state_q == S_CLEAR) begin
      we0 = 1'b1;
      we1 = 1'b1;
    end else if (state_q == S_SWEEP) begin
      we0 = recent_q;
      we1 = !recent_q;
    end else if (state_q == S_INS || state_q == S_REINS) begin
      we0 = !recent_q;
      we1 = recent_q;
    end
  end

  tbabf_ram #(.WIDTH(1), .DEPTH(SIZE)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd0)
  );

  tbabf_ram #(.WIDTH(1), .DEPTH(SIZE)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd1)
  );

  always_comb begin
    logic rotate;
    rotate        = 1'b0;
    state_d       = state_q;
    cnt_d         = cnt_q;
    sweep_d       = sweep_q;
    uniq_d        = uniq_q;
    rz_d          = rz_q;
    oz_d          = oz_q;
    lookup_d      = lookup_q;
    present_d     = present_q;
    recent_d      = recent_q;
    fill_d        = fill_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_present_d = out_present_q;
    for (int i = 0; i < NHASH; i++) begin
      pos_d[i] = pos_q[i];
    end

    unique case (state_q) inside
      S_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(SIZE - 1)) begin
          sweep_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < NHASH; i++) begin
            pos_d[i] = pos_in[i];
          end
          uniq_d   = uniq_in;
          lookup_d = lookup_only_i;
          cnt_d    = '0;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        // address out at step cnt, data back at step cnt+1
        if (cnt_q != CNW'(NHASH)) begin
          rotate = 1'b1;
        end
        if (cnt_q != '0) begin
          rz_d = rz_q >> 1;
          oz_d = oz_q >> 1;
          rz_d[NHASH-1] = !rd_recent;
          oz_d[NHASH-1] = !rd_old;
        end
        cnt_d = cnt_q + CNW'(1);
        if (cnt_q == CNW'(NHASH)) begin
          cnt_d   = '0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rz_q == '0) begin
          present_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          present_d = (oz_q == '0);
          if (!lookup_q) begin
            fill_d  = fill_q + pop(rz_q & uniq_q);
            state_d = S_INS;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_INS, S_REINS: begin
        rotate = 1'b1;
        cnt_d  = cnt_q + CNW'(1);
        if (cnt_q == CNW'(NHASH - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == S_INS) ? S_CHK : S_DONE;
        end
      end
      S_CHK: begin
        if (CMPW'(fill_q) >= CMPW'(thr_q)) begin
          state_d = S_SWEEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SWEEP: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(SIZE - 1)) begin
          sweep_d  = '0;
          recent_d = !recent_q;
          // fresh bank is empty, so every distinct position is new
          if (lookup_q) begin
            fill_d  = '0;
            state_d = S_DONE;
          end else begin
            fill_d  = pop(uniq_q);
            state_d = S_REINS;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_present_d = present_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rotate) begin
      for (int i = 0; i < NHASH - 1; i++) begin
        pos_d[i] = pos_q[i+1];
      end
      pos_d[NHASH-1] = pos_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      sweep_q     <= '0;
      recent_q    <= 1'b0;
      fill_q      <= '0;
      thr_q       <= tbabf_pkg::THR_W'(tbabf_pkg::THR_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sweep_q     <= sweep_d;
      recent_q    <= recent_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= swap_threshold_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NHASH; i++) begin
      pos_q[i] <= pos_d[i];
    end
    uniq_q        <= uniq_d;
    rz_q          <= rz_d;
    oz_q          <= oz_d;
    lookup_q      <= lookup_d;
    present_q     <= present_d;
    out_present_q <= out_present_d;
  end

endmodule

FILE: sv/tbabf_ram.sv
// ----------------------------------------------------------------------------
// tbabf_ram: generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module tbabf_ram #(
  parameter int WIDTH = tbabf_pkg::RAM_W_DEFAULT,
  parameter int DEPTH = tbabf_pkg::SIZE_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/sv/tb_two_bank_aging_bloom_filter_top.sv
// ----------------------------------------------------------------------------
// tb_two_bank_aging_bloom_filter_top: self-checking bench for the ageing filter
// A short table of hand-picked queries, then random phases under several swap
// thresholds. Every query beat runs through a bit-level copy of both banks
// here; each present beat is checked in order against it or a typed value.
// ----------------------------------------------------------------------------
module tb_two_bank_aging_bloom_filter_top;

  localparam int IDX_W     = tbabf_pkg::IDX_W;
  localparam int THR_W     = tbabf_pkg::THR_W;
  localparam int THR_RESET = tbabf_pkg::THR_RESET;
  localparam int SIZE      = tbabf_pkg::SIZE_DEFAULT;
  localparam int NHASH     = tbabf_pkg::NHASH_DEFAULT;

  // A swap sweeps SIZE addresses and then re-inserts the query, so that is the
  // longest the block can go quiet. Threshold writes wait this long after the
  // last result, and the watchdog allows several times that.
  localparam int SWEEP_SETTLE   = SIZE + 4 * NHASH + 32;
  localparam int WATCHDOG_LIMIT = 5 * SWEEP_SETTLE;
  localparam int END_WAIT       = 64;
  localparam int POOL_KEYS      = 32;
  localparam int MAX_REPORTS    = 40;
  localparam int NUM_PHASES     = 7;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [3:0][IDX_W-1:0] idx;
    logic                  lookup;
  } query_t;

  // How a table row is checked: a typed value, or whatever the bank copy says.
  typedef enum logic [1:0] {
    EXP_ABSENT,
    EXP_PRESENT,
    EXP_PREDICT
  } row_exp_e;

  typedef struct packed {
    logic             wr_thr;
    logic [THR_W-1:0] thr;
    query_t           q;
    row_exp_e         ek;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [IDX_W-1:0] index_0_i;
  logic [IDX_W-1:0] index_1_i;
  logic [IDX_W-1:0] index_2_i;
  logic [IDX_W-1:0] index_3_i;
  logic             lookup_only_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             present_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [THR_W-1:0] swap_threshold_i;

  two_bank_aging_bloom_filter_top #(
    .SIZE  (SIZE),
    .NHASH (NHASH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .index_0_i        (index_0_i),
    .index_1_i        (index_1_i),
    .index_2_i        (index_2_i),
    .index_3_i        (index_3_i),
    .lookup_only_i    (lookup_only_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .present_o        (present_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .swap_threshold_i (swap_threshold_i)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the filter state
  // --------------------------------------------------------------------------
  bit [SIZE-1:0]    bank_q [2];
  bit               recent_sel = 1'b0;        // bank 0 is recent after reset
  int unsigned      fill_cnt   = 0;
  logic [THR_W-1:0] thr_cur    = THR_W'(THR_RESET);

  logic     present_due [$];                  // present values still owed
  row_exp_e pending_ek = EXP_PREDICT;         // check kind of the beat on the bus
  query_t   key_pool [POOL_KEYS];
  dir_row_t dir_rows [$];

  bit          calm = 1'b0;                   // last phase: no idling either side
  int          stall_left  = 0;
  int          stall_quiet = 0;
  int          send_quiet  = 0;
  int unsigned queries_sent  = 0;
  int unsigned results_seen  = 0;
  int unsigned present_count = 0;
  int unsigned swap_count    = 0;
  int unsigned thr_writes    = 0;
  int unsigned errors        = 0;

  // Set the query's bits in the recent bank; each 0 -> 1 bumps the fill count.
  function automatic void set_recent_bits(query_t q);
    int p;
    for (int k = 0; k < NHASH; k++) begin
      p = int'(q.idx[k]) % SIZE;
      if (!bank_q[recent_sel][p]) begin
        bank_q[recent_sel][p] = 1'b1;
        if (fill_cnt < SIZE) fill_cnt++;
      end
    end
  endfunction

  // One query against the bank copy: returns present and ages the banks.
  function automatic logic filter_query(query_t q);
    logic hit_recent;
    logic hit_old;
    int   p;
    hit_recent = 1'b1;
    hit_old    = 1'b1;
    for (int k = 0; k < NHASH; k++) begin
      p = int'(q.idx[k]) % SIZE;
      if (!bank_q[recent_sel][p]) hit_recent = 1'b0;
      if (!bank_q[recent_sel ^ 1'b1][p]) hit_old = 1'b0;
    end
    if (hit_recent) return 1'b1;
    if (!q.lookup) set_recent_bits(q);
    // threshold is checked on every recent miss, lookup-only ones too
    if (fill_cnt >= thr_cur) begin
      bank_q[recent_sel ^ 1'b1] = '0;
      recent_sel = recent_sel ^ 1'b1;
      fill_cnt   = 0;
      swap_count++;
      if (!q.lookup) set_recent_bits(q);
    end
    return hit_old;
  endfunction

  function automatic query_t random_key();
    query_t q;
    for (int k = 0; k < 4; k++) q.idx[k] = idx_t'($urandom);
    q.lookup = 1'($urandom_range(1));
    return q;
  endfunction

  // Mostly keys from a small pool so recent and old hits both happen; the rest
  // are pool keys with a bent index, keys with a repeated index, and noise.
  function automatic query_t next_query();
    query_t      q;
    int unsigned pick;
    int unsigned mode;
    pick = $urandom_range(POOL_KEYS - 1);
    mode = $urandom_range(99);
    if ($urandom_range(15) == 0) key_pool[pick] = random_key();
    q = key_pool[pick];
    q.lookup = ($urandom_range(2) == 0);
    if (mode >= 90) begin
      q = random_key();
    end else if (mode >= 80) begin
      q.idx[$urandom_range(NHASH - 1)] = idx_t'($urandom);
    end else if (mode >= 75) begin
      q.idx[1] = q.idx[0];
    end
    return q;
  endfunction

  function automatic dir_row_t row(int wr, int thr, int i0, int i1, int i2, int i3,
                                   int lk, row_exp_e ek);
    dir_row_t r;
    r.wr_thr = 1'(wr);
    r.thr    = THR_W'(thr);
    r.q.idx[0] = idx_t'(i0);
    r.q.idx[1] = idx_t'(i1);
    r.q.idx[2] = idx_t'(i2);
    r.q.idx[3] = idx_t'(i3);
    r.q.lookup = 1'(lk);
    r.ek       = ek;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: random bursts of stalled cycles, with the odd
  // long quiet stretch, and none at all once calm is set.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (stall_quiet != 0) begin
        stall_quiet--;
      end else if (!calm) begin
        if ($urandom_range(39) == 0) begin
          stall_quiet = $urandom_range(20, 150);
        end else if ($urandom_range(4) == 0) begin
          stall_left = $urandom_range(1, 8);
        end
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Beat monitor: predict on every accepted query beat, check every accepted
  // result beat against the oldest owed value. Query side goes first so the
  // queue order always matches acceptance order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    query_t q_now;
    logic   predicted;
    logic   owed;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      q_now.idx[0] = index_0_i;
      q_now.idx[1] = index_1_i;
      q_now.idx[2] = index_2_i;
      q_now.idx[3] = index_3_i;
      q_now.lookup = lookup_only_i;
      predicted    = filter_query(q_now);
      queries_sent++;
      case (pending_ek)
        EXP_ABSENT:  present_due = {present_due, 1'b0};
        EXP_PRESENT: present_due = {present_due, 1'b1};
        default:     present_due = {present_due, predicted};
      endcase
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (present_o === 1'b1) present_count++;
      if (present_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat %0d with nothing owed: expected none, got present=%b",
                   $time, results_seen, present_o);
      end else begin
        owed = present_due.pop_front();
        if (present_o !== owed) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat %0d: present expected %b, got %b",
                     $time, results_seen, owed, present_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no channel moves a beat for too long.
  // --------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat on any channel for %0d cycles, %0d results still owed",
                 $time, WATCHDOG_LIMIT, present_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one query beat, with an optional gap first; returns at the edge
  // that accepts it. Valid stays high into the next call unless a gap follows.
  task automatic send_query(input query_t q, input row_exp_e ek);
    int gap;
    gap = 0;
    if (send_quiet != 0) begin
      send_quiet--;
    end else if (!calm) begin
      if ($urandom_range(49) == 0) begin
        send_quiet = $urandom_range(20, 120);
      end else if ($urandom_range(3) == 0) begin
        gap = $urandom_range(1, 8);
      end
    end
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    index_0_i     <= q.idx[0];
    index_1_i     <= q.idx[1];
    index_2_i     <= q.idx[2];
    index_3_i     <= q.idx[3];
    lookup_only_i <= q.lookup;
    pending_ek     = ek;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off until every owed result is in; with sweep_pause also sit out a
  // full clear sweep so the block is certainly idle.
  task automatic wait_for_results(input bit sweep_pause);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (present_due.size() != 0) @(posedge clk_i);
    if (sweep_pause) repeat (SWEEP_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    swap_threshold_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    thr_cur = value;
    thr_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_thr [NUM_PHASES];
    int          phase_len [NUM_PHASES];

    in_valid_i       = 1'b0;
    index_0_i        = '0;
    index_1_i        = '0;
    index_2_i        = '0;
    index_3_i        = '0;
    lookup_only_i    = 1'b0;
    cfg_valid_i      = 1'b0;
    swap_threshold_i = '0;
    bank_q[0]        = '0;
    bank_q[1]        = '0;
    rst_ni           = 1'b0;

    for (int k = 0; k < POOL_KEYS; k++) key_pool[k] = random_key();

    // Directed table. Typed results only where obvious: empty banks, and
    // straight hits in the recent bank before any swap has happened.
    //                          wr  thr   idx0     idx1     idx2     idx3   lk   check
    dir_rows = {dir_rows, row(0,    0, 12'h000, 12'h000, 12'h000, 12'h000, 1, EXP_ABSENT)};
    // ends of the index range, each repeated within the query
    dir_rows = {dir_rows, row(0,    0, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 0, EXP_ABSENT)};
    dir_rows = {dir_rows, row(0,    0, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 1, EXP_PRESENT)};
    dir_rows = {dir_rows, row(0,    0, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 0, EXP_ABSENT)};
    dir_rows = {dir_rows, row(0,    0, 12'h555, 12'hAAA, 12'h000, 12'hFFF, 1, EXP_PRESENT)};
    // threshold zero: every recent miss swaps, lookup-only misses as well
    dir_rows = {dir_rows, row(1,    0, 12'h001, 12'h002, 12'h003, 12'h004, 0, EXP_ABSENT)};
    dir_rows = {dir_rows, row(0,    0, 12'h000, 12'hFFF, 12'h555, 12'hAAA, 1, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h000, 12'hFFF, 12'h555, 12'hAAA, 1, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h001, 12'h002, 12'h003, 12'h004, 0, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h001, 12'h002, 12'h003, 12'h004, 1, EXP_PREDICT)};
    // largest threshold: as good as never swapping
    dir_rows = {dir_rows, row(1, 4096, 12'hFFF, 12'hFFE, 12'hFFD, 12'hFFC, 0, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h800, 12'h400, 12'h200, 12'h100, 0, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h800, 12'h400, 12'h200, 12'h100, 1, EXP_PREDICT)};
    // threshold one, one index four times over: counted once, then swapped
    dir_rows = {dir_rows, row(1,    1, 12'h007, 12'h007, 12'h007, 12'h007, 0, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h007, 12'h007, 12'h007, 12'h007, 1, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h001, 12'h002, 12'h003, 12'h004, 1, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'hFFF, 12'hFFE, 12'hFFD, 12'hFFC, 0, EXP_PREDICT)};
    dir_rows = {dir_rows, row(1, 4095, 12'h123, 12'h456, 12'h789, 12'hABC, 0, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'h123, 12'h456, 12'h789, 12'hABC, 1, EXP_PREDICT)};
    dir_rows = {dir_rows, row(0,    0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0, EXP_PREDICT)};

    // Random phases: threshold and query count. Small thresholds get few
    // queries since every swap costs a full sweep; the last phase runs calm.
    phase_thr[0] = 0;                        phase_len[0] = 12;
    phase_thr[1] = 1;                        phase_len[1] = 30;
    phase_thr[2] = $urandom_range(48, 64);   phase_len[2] = 250;
    phase_thr[3] = 4095;                     phase_len[3] = 200;
    phase_thr[4] = 4096;                     phase_len[4] = 100;
    phase_thr[5] = $urandom_range(100, 400); phase_len[5] = 300;
    phase_thr[6] = THR_RESET;                phase_len[6] = 450;

    // reset is held, then released away from the rising edge; the block
    // then clears both banks and holds the query side off while it does
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr_thr) begin
        wait_for_results(1'b1);
        write_threshold(dir_rows[r].thr);
      end
      send_query(dir_rows[r].q, dir_rows[r].ek);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results(1'b1);
      write_threshold(THR_W'(phase_thr[p]));
      calm = (p == NUM_PHASES - 1);
      for (int n = 0; n < phase_len[p]; n++) begin
        // once mid-run the sender holds back until everything is answered
        if (p == 2 && n == phase_len[p] / 2) wait_for_results(1'b0);
        send_query(next_query(), EXP_PREDICT);
      end
    end

    wait_for_results(1'b0);
    repeat (END_WAIT) @(posedge clk_i);

    $display("Covered %0d queries (%0d table rows) over %0d threshold writes; %0d present.",
             queries_sent, dir_rows.size(), thr_writes, present_count);
    $display("Bank swaps seen by the bench copy: %0d; result beats checked: %0d; mismatches: %0d.",
             swap_count, results_seen, errors);
    if (errors == 0 && present_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tbabf_pkg.sv
sv/tbabf_ram.sv
sv/two_bank_aging_bloom_filter_top.sv
tb/sv/tb_two_bank_aging_bloom_filter_top.sv
